@@ rtl/jtfs_pkg.sv @@
// Package for the JSON top-level field splitter.
// Holds character codes, caps and the front-to-back queue entry type.
// No dependencies.
`default_nettype none

package jtfs_pkg;

    localparam int POS_W   = 16;
    localparam int DEPTH_W = 8;
    localparam int CNT_W   = 8;

    localparam logic [POS_W-1:0]   POS_CAP   = 16'hFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_CAP = 8'd127;
    localparam logic [CNT_W-1:0]   SEG_CAP   = 8'd255;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // one entry: an optional segment result followed by an optional summary
    typedef struct packed {
        logic             has_seg;
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
        logic [CNT_W-1:0] seg_index;
        logic             has_sum;
        logic [CNT_W-1:0] sum_count;
        logic             sum_match;
        logic             sum_fault;
    } jtfs_entry_t;

endpackage

`default_nettype wire

@@ rtl/json_top_level_field_splitter_core.sv @@
// JSON top-level field splitter: front parser, 4-entry queue, output stage.
// Each result is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue is not full; a last byte
// that also closes a field gives a segment beat and then a summary beat.
// Reset: synchronous active-low aresetn clears parser state, queue and
// expected_segments (to 0). Depends on jtfs_pkg, jtfs_front/queue/back.
`default_nettype none

module json_top_level_field_splitter_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [7:0]  cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_char_byte,
    input  wire         s_end_of_message,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_is_summary,
    output logic [15:0] m_seg_start,
    output logic [15:0] m_seg_end,
    output logic [7:0]  m_seg_index,
    output logic        m_count_match,
    output logic        m_depth_fault,
    output logic        m_last_result
);
    import jtfs_pkg::*;

    jtfs_entry_t push_entry;
    jtfs_entry_t pop_entry;
    logic        push;
    logic        q_ready;
    logic        q_valid;
    logic        pop;

    jtfs_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_byte      (s_char_byte),
        .s_end_of_message (s_end_of_message),
        .q_ready          (q_ready),
        .q_push           (push),
        .q_entry          (push_entry)
    );

    jtfs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .in_ready   (q_ready),
        .pop        (pop),
        .out_valid  (q_valid),
        .out_entry  (pop_entry)
    );

    jtfs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (pop_entry),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_summary  (m_is_summary),
        .m_seg_start   (m_seg_start),
        .m_seg_end     (m_seg_end),
        .m_seg_index   (m_seg_index),
        .m_count_match (m_count_match),
        .m_depth_fault (m_depth_fault),
        .m_last_result (m_last_result)
    );

endmodule

`default_nettype wire

@@ rtl/jtfs_front.sv @@
// Front end: accepts message bytes, tracks depth/string/field state and
// pushes segment and summary records into the queue. Uses jtfs_pkg.
`default_nettype none

module jtfs_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [7:0]            cfg_wr_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire [7:0]            s_char_byte,
    input  wire                  s_end_of_message,
    input  wire                  q_ready,
    output logic                 q_push,
    output jtfs_pkg::jtfs_entry_t q_entry
);
    import jtfs_pkg::*;

    logic [CNT_W-1:0]   expected_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               in_str_reg, in_str_next;
    logic               open_reg, open_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               fault_reg, fault_next;
    logic               close_req;
    logic               emit_seg;
    logic               accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        depth_next  = depth_reg;
        in_str_next = in_str_reg;
        open_next   = open_reg;
        start_next  = start_reg;
        fault_next  = fault_reg;
        close_req   = 1'b0;

        if (in_str_reg) begin
            if (s_char_byte == CH_QUOTE) begin
                in_str_next = 1'b0;
            end
        end else if (s_char_byte == CH_QUOTE) begin
            in_str_next = 1'b1;
            if (depth_reg == DEPTH_W'(1) && !open_reg) begin
                open_next  = 1'b1;
                start_next = (pos_reg == POS_CAP) ? POS_CAP : pos_reg + POS_W'(1);
            end
        end else if (s_char_byte == CH_LBRACE || s_char_byte == CH_LBRACK) begin
            if (depth_reg >= DEPTH_CAP) begin
                fault_next = 1'b1;
            end else begin
                depth_next = depth_reg + DEPTH_W'(1);
            end
        end else if (s_char_byte == CH_RBRACE || s_char_byte == CH_RBRACK) begin
            if (depth_reg == '0) begin
                fault_next = 1'b1;
            end else begin
                depth_next = depth_reg - DEPTH_W'(1);
                close_req  = (s_char_byte == CH_RBRACE) && (depth_reg == DEPTH_W'(1))
                             && open_reg;
            end
        end else if (s_char_byte == CH_COMMA) begin
            close_req = (depth_reg == DEPTH_W'(1)) && open_reg;
        end

        emit_seg   = close_req && (count_reg < SEG_CAP);
        count_next = emit_seg ? count_reg + CNT_W'(1) : count_reg;
        if (close_req) begin
            open_next = 1'b0;
        end
        pos_next = (pos_reg < POS_CAP) ? pos_reg + POS_W'(1) : pos_reg;

        q_entry.has_seg   = emit_seg;
        q_entry.seg_start = start_reg;
        q_entry.seg_end   = pos_reg;
        q_entry.seg_index = count_reg;
        q_entry.has_sum   = s_end_of_message;
        q_entry.sum_count = count_next;
        q_entry.sum_match = (count_next == expected_reg);
        q_entry.sum_fault = fault_next;
        q_push = accept && (emit_seg || s_end_of_message);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= '0;
            depth_reg    <= '0;
            in_str_reg   <= 1'b0;
            open_reg     <= 1'b0;
            start_reg    <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            fault_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                expected_reg <= cfg_wr_data;
            end
            if (accept) begin
                if (s_end_of_message) begin
                    depth_reg  <= '0;
                    in_str_reg <= 1'b0;
                    open_reg   <= 1'b0;
                    start_reg  <= '0;
                    pos_reg    <= '0;
                    count_reg  <= '0;
                    fault_reg  <= 1'b0;
                end else begin
                    depth_reg  <= depth_next;
                    in_str_reg <= in_str_next;
                    open_reg   <= open_next;
                    start_reg  <= start_next;
                    pos_reg    <= pos_next;
                    count_reg  <= count_next;
                    fault_reg  <= fault_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/jtfs_queue.sv @@
// Short register FIFO between front and back end.
// Uses jtfs_pkg for the entry type and depth.
`default_nettype none

module jtfs_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  jtfs_pkg::jtfs_entry_t push_entry,
    output logic                  in_ready,
    input  wire                   pop,
    output logic                  out_valid,
    output jtfs_pkg::jtfs_entry_t out_entry
);
    import jtfs_pkg::*;

    jtfs_entry_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     fill_reg;
    logic                  do_push;
    logic                  do_pop;

    assign in_ready  = (fill_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_entry = mem[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/jtfs_back.sv @@
// Back end: takes queue entries into an output register and sends the
// segment beat, then the summary beat, of each, where present. Uses jtfs_pkg.
`default_nettype none

module jtfs_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   q_valid,
    input  jtfs_pkg::jtfs_entry_t q_entry,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_is_summary,
    output logic [15:0]           m_seg_start,
    output logic [15:0]           m_seg_end,
    output logic [7:0]            m_seg_index,
    output logic                  m_count_match,
    output logic                  m_depth_fault,
    output logic                  m_last_result
);
    import jtfs_pkg::*;

    jtfs_entry_t ent_reg;
    logic        valid_reg;
    logic        seg_done_reg;
    logic        sum_beat;
    logic        final_beat;

    assign sum_beat   = seg_done_reg || !ent_reg.has_seg;
    assign final_beat = sum_beat || !ent_reg.has_sum;
    assign q_pop      = q_valid && (!valid_reg || (m_ready && final_beat));

    assign m_valid       = valid_reg;
    assign m_is_summary  = sum_beat;
    assign m_seg_start   = sum_beat ? '0 : ent_reg.seg_start;
    assign m_seg_end     = sum_beat ? '0 : ent_reg.seg_end;
    assign m_seg_index   = sum_beat ? ent_reg.sum_count : ent_reg.seg_index;
    assign m_count_match = sum_beat && ent_reg.sum_match;
    assign m_depth_fault = sum_beat && ent_reg.sum_fault;
    assign m_last_result = final_beat;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            seg_done_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                valid_reg    <= 1'b1;
                seg_done_reg <= 1'b0;
            end else if (valid_reg && m_ready) begin
                if (final_beat) begin
                    valid_reg <= 1'b0;
                end else begin
                    seg_done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_json_top_level_field_splitter_core.sv @@
// Testbench for json_top_level_field_splitter_core: streams JSON-like messages,
// predicts field segment and summary beats, and checks every result beat in order.
// Depends on jtfs_pkg and the splitter RTL.
`timescale 1ns / 1ps

module tb_json_top_level_field_splitter_core;
    import jtfs_pkg::*;

    typedef struct {
        logic        is_summary;
        logic [15:0] start_off;
        logic [15:0] end_off;
        logic [7:0]  index;
        logic        match;
        logic        fault;
        logic        last;
    } split_beat_t;

    class segment_tracker;
        logic [7:0]  expected_segs;
        logic [7:0]  depth;
        logic        in_str;
        logic        field_open;
        logic [15:0] open_start;
        logic [15:0] byte_pos;
        logic [7:0]  seg_count;
        logic        fault;
        split_beat_t owed_beats[$];
        int          errors;
        int          bytes_seen;
        int          seg_beats;
        int          sum_beats;
        int          matched_sums;
        int          faults;

        function new();
            expected_segs = 8'd0;
            errors = 0;
            bytes_seen = 0;
            seg_beats = 0;
            sum_beats = 0;
            matched_sums = 0;
            faults = 0;
            clear();
        endfunction

        function void clear();
            depth = '0;
            in_str = 1'b0;
            field_open = 1'b0;
            open_start = '0;
            byte_pos = '0;
            seg_count = '0;
            fault = 1'b0;
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        function void take_byte(logic [7:0] ch, logic eom);
            split_beat_t outs[2];
            int          n;
            logic        closes;
            logic [15:0] here;
            n = 0;
            closes = 1'b0;
            here = byte_pos;
            bytes_seen++;
            if (in_str) begin
                if (ch == CH_QUOTE) in_str = 1'b0;
            end else if (ch == CH_QUOTE) begin
                in_str = 1'b1;
                if (depth == 8'd1 && !field_open) begin
                    field_open = 1'b1;
                    open_start = (here == 16'hFFFF) ? 16'hFFFF : here + 16'd1;
                end
            end else if (ch == CH_LBRACE || ch == CH_LBRACK) begin
                if (depth >= DEPTH_CAP) fault = 1'b1;
                else depth++;
            end else if (ch == CH_RBRACE || ch == CH_RBRACK) begin
                if (depth == 8'd0) begin
                    fault = 1'b1;
                end else begin
                    depth--;
                    closes = (ch == CH_RBRACE && depth == 8'd0 && field_open);
                end
            end else if (ch == CH_COMMA) begin
                closes = (depth == 8'd1 && field_open);
            end
            if (closes) begin
                field_open = 1'b0;
                if (seg_count < SEG_CAP) begin
                    outs[n].is_summary = 1'b0;
                    outs[n].start_off = open_start;
                    outs[n].end_off = here;
                    outs[n].index = seg_count;
                    outs[n].match = 1'b0;
                    outs[n].fault = 1'b0;
                    outs[n].last = 1'b0;
                    n++;
                    seg_count++;
                end
            end
            if (byte_pos != POS_CAP) byte_pos++;
            if (eom) begin
                outs[n].is_summary = 1'b1;
                outs[n].start_off = '0;
                outs[n].end_off = '0;
                outs[n].index = seg_count;
                outs[n].match = (seg_count == expected_segs);
                outs[n].fault = fault;
                outs[n].last = 1'b0;
                n++;
                clear();
            end
            if (n > 0) outs[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) owed_beats.insert(owed_beats.size(), outs[i]);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void match_beat(split_beat_t got);
            split_beat_t want;
            if (owed_beats.size() == 0) begin
                errors++;
                $error("unexpected result beat: is_summary %0d seg_index %0d",
                       got.is_summary, got.index);
                return;
            end
            want = owed_beats.pop_front();
            compare_field("is_summary", want.is_summary, got.is_summary);
            compare_field("seg_start", want.start_off, got.start_off);
            compare_field("seg_end", want.end_off, got.end_off);
            compare_field("seg_index", want.index, got.index);
            compare_field("count_match", want.match, got.match);
            compare_field("depth_fault", want.fault, got.fault);
            compare_field("last_result", want.last, got.last);
            if (want.is_summary) begin
                sum_beats++;
                if (want.match) matched_sums++;
                if (want.fault) faults++;
            end else begin
                seg_beats++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_byte;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic        m_is_summary;
    logic [15:0] m_seg_start;
    logic [15:0] m_seg_end;
    logic [7:0]  m_seg_index;
    logic        m_count_match;
    logic        m_depth_fault;
    logic        m_last_result;

    segment_tracker tracker = new();
    logic [7:0]     msg_bytes[$];
    int             burst_left = 0;
    int             rx_mode = 0;
    int             rx_left = 0;

    json_top_level_field_splitter_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_byte      (s_char_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_summary     (m_is_summary),
        .m_seg_start      (m_seg_start),
        .m_seg_end        (m_seg_end),
        .m_seg_index      (m_seg_index),
        .m_count_match    (m_count_match),
        .m_depth_fault    (m_depth_fault),
        .m_last_result    (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("json_top_level_field_splitter_core test failed");
        $finish;
    end

    // result side: check accepted beats, stall in changing modes
    always @(posedge aclk) begin
        split_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.is_summary = m_is_summary;
            got.start_off = m_seg_start;
            got.end_off = m_seg_end;
            got.index = m_seg_index;
            got.match = m_count_match;
            got.fault = m_depth_fault;
            got.last = m_last_result;
            tracker.match_beat(got);
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 0);
            2: m_ready <= ($urandom_range(0, 9) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic push_byte(input logic [7:0] ch, input logic eom);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_char_byte <= ch;
        s_end_of_message <= eom;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_byte(ch, eom);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task automatic append_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endtask

    task automatic write_expected(input logic [7:0] v);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.expected_segs = v;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = CH_COMMA;
            1: b = CH_LBRACE;
            2: b = CH_RBRACE;
            3: b = CH_LBRACK;
            4: b = CH_RBRACK;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == CH_QUOTE) b = 8'h61;
        return b;
    endfunction

    task automatic add_value(input int lvl);
        int n;
        case ((lvl >= 3) ? $urandom_range(0, 2) : $urandom_range(0, 4))
            0: begin
                n = $urandom_range(1, 3);
                repeat (n) append_byte(8'h30 + 8'($urandom_range(0, 9)));
            end
            1: begin
                append_byte(CH_QUOTE);
                n = $urandom_range(0, 5);
                repeat (n) append_byte(text_byte());
                append_byte(CH_QUOTE);
            end
            2: add_text("true");
            3: begin
                append_byte(CH_LBRACK);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) append_byte(CH_COMMA);
                    add_value(lvl + 1);
                end
                append_byte(CH_RBRACK);
            end
            default: begin
                append_byte(CH_LBRACE);
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++) begin
                    if (i != 0) append_byte(CH_COMMA);
                    add_text("\"k\":");
                    add_value(lvl + 1);
                end
                append_byte(CH_RBRACE);
            end
        endcase
    endtask

    // object with nf fields and random content; some are broken on purpose
    task automatic build_message(input int nf);
        int klen;
        msg_bytes.delete();
        append_byte(CH_LBRACE);
        for (int i = 0; i < nf; i++) begin
            if (i != 0) append_byte(CH_COMMA);
            if ($urandom_range(0, 3) == 0) append_byte(8'h20);
            append_byte(CH_QUOTE);
            klen = $urandom_range(0, 4);
            repeat (klen) append_byte(text_byte());
            append_byte(CH_QUOTE);
            append_byte(8'h3A);
            add_value(1);
        end
        append_byte(CH_RBRACE);
        case ($urandom_range(0, 19))
            0: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            1: msg_bytes.pop_back();
            2: append_byte(CH_RBRACE);
            3: msg_bytes.insert($urandom_range(0, msg_bytes.size() - 1), CH_QUOTE);
            4: begin
                msg_bytes.delete();
                klen = $urandom_range(1, 12);
                repeat (klen) append_byte(8'($urandom_range(0, 255)));
            end
            5: begin
                msg_bytes.push_front(CH_LBRACK);
                append_byte(CH_RBRACK);
            end
            default: ;
        endcase
    endtask

    initial begin
        string       simple_msgs[7];
        logic [7:0]  phase_cfg[6];
        int          sent;
        int          nf;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        s_valid = 1'b0;
        s_char_byte = 8'd0;
        s_end_of_message = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed messages with the reset value of expected_segments
        simple_msgs = '{"{}",
                        "{\"a\":1,\"bb\":[1,{\"c\":2}],\"d\":\"x,}]{[\"}",
                        "}]",
                        "[\"a\",1]",
                        "{\"a\"}",
                        "{\"k\":1,",
                        "\""};
        foreach (simple_msgs[i]) begin
            msg_bytes.delete();
            add_text(simple_msgs[i]);
            send_message();
        end
        msg_bytes = '{8'h00};
        send_message();
        msg_bytes = '{8'hFF};
        send_message();
        // depth overflow past the cap, then back down and below zero
        msg_bytes.delete();
        repeat (129) append_byte(CH_LBRACE);
        repeat (130) append_byte(CH_RBRACE);
        send_message();

        phase_cfg = '{8'd3, 8'd0, 8'd255, 8'd1, 8'($urandom_range(0, 255)), 8'd2};
        foreach (phase_cfg[p]) begin
            write_expected(phase_cfg[p]);
            if (phase_cfg[p] == 8'd255) begin
                // more fields than the segment counter holds
                msg_bytes.delete();
                append_byte(CH_LBRACE);
                for (int i = 0; i < 258; i++) begin
                    if (i != 0) append_byte(CH_COMMA);
                    add_text("\"\"");
                end
                append_byte(CH_RBRACE);
                send_message();
            end
            sent = 0;
            while (sent < 100) begin
                if (phase_cfg[p] <= 8'd6 && $urandom_range(0, 2) != 0)
                    nf = phase_cfg[p];
                else
                    nf = $urandom_range(0, 6);
                build_message(nf);
                sent += msg_bytes.size();
                send_message();
            end
        end

        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("streamed %0d bytes; checked %0d field beats and %0d summaries",
                 tracker.bytes_seen, tracker.seg_beats, tracker.sum_beats);
        $display("summaries with count match: %0d, with depth fault: %0d",
                 tracker.matched_sums, tracker.faults);
        if (tracker.errors == 0) begin
            $display("json_top_level_field_splitter_core test passed");
        end else begin
            $display("json_top_level_field_splitter_core test failed");
        end
        $finish;
    end

endmodule
